// ----- rtl/pidaw_pkg.sv -----
package pidaw_pkg;

    // defaults for the top-level parameters
    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // fixed field widths
    localparam int ERROR_W     = 32;
    localparam int TIME_W      = 16;
    localparam int TIME_FRAC   = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // operation codes on the operation input
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_UPPER = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_UPPER   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LOWER   = 3'd6;

    // request to the serial multiplier
    typedef struct packed {
        logic start;
        logic time_shift;   // shift product by TIME_FRAC instead of FRAC_BITS
    } t_mul_req;

endpackage

// ----- rtl/pidaw_mul.sv -----
module pidaw_mul #(
    parameter int DATA_WIDTH = pidaw_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = pidaw_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pidaw_pkg::t_mul_req         i_req,
    input  logic signed [DATA_WIDTH:0]  i_a,
    input  logic signed [DATA_WIDTH:0]  i_b,
    output logic                        o_done,
    output logic signed [DATA_WIDTH-1:0] o_prod
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    logic          r_busy, r_fin, r_done, r_neg, r_tshift;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_ma, r_mb;
    logic [PW-1:0] r_acc;
    logic signed [DW-1:0] r_prod;

    logic [DW:0]   a_abs, b_abs;
    logic [DW:0]   n_sum;
    logic [PW-1:0] m_sel, lim, m_clip;
    logic [DW-1:0] n_mag;

    assign a_abs = i_a[DW] ? -i_a : i_a;
    assign b_abs = i_b[DW] ? -i_b : i_b;

    // shift-and-add, one multiplier bit per cycle, LSB first
    assign n_sum = {1'b0, r_acc[PW-1:DW]} + (r_mb[0] ? {1'b0, r_ma} : '0);

    // truncate, then saturate the magnitude to the signed range
    assign m_sel  = r_tshift ? (r_acc >> TIME_FRAC) : (r_acc >> FRAC_BITS);
    assign lim    = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}} + PW'(r_neg);
    assign m_clip = (m_sel > lim) ? lim : m_sel;
    assign n_mag  = m_clip[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt    <= '0;
            r_ma     <= a_abs[DW-1:0];
            r_mb     <= b_abs[DW-1:0];
            r_acc    <= '0;
            r_neg    <= i_a[DW] ^ i_b[DW];
            r_tshift <= i_req.time_shift;
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[DW-1:1]};
            r_mb  <= r_mb >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fin) begin
            r_prod <= r_neg ? -n_mag : n_mag;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- rtl/pidaw_div.sv -----
module pidaw_div #(
    parameter int DATA_WIDTH = pidaw_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DATA_WIDTH-1:0]         i_mag,
    input  logic                          i_neg,
    input  logic [pidaw_pkg::TIME_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic signed [DATA_WIDTH-1:0]  o_quot
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + TIME_FRAC;
    localparam int CW = $clog2(NW);

    logic              r_busy, r_fin, r_done, r_neg;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_num;
    logic [TIME_W-1:0] r_rem, r_den;
    logic signed [DW-1:0] r_quot;

    logic [TIME_W:0]   trial, diff;
    logic              ge;
    logic [NW-1:0]     lim, q_clip;
    logic [DW-1:0]     q_mag;

    // restoring division, one quotient bit per cycle; quotient shifts into r_num
    assign trial = {r_rem, r_num[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    assign lim    = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}} + NW'(r_neg);
    assign q_clip = (r_num > lim) ? lim : r_num;
    assign q_mag  = q_clip[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_num <= {i_mag, {TIME_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_num <= {r_num[NW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fin) begin
            r_quot <= r_neg ? -q_mag : q_mag;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/pid_controller_antiwindup.sv -----
// A clear goes from the input transfer straight to the result; a control step runs the multiplier
// for P, error times time step and I, then, with a nonzero time step, the divider and the
// multiplier for D. Output stalls hold the sequencer in FINISH.
// One item at a time, the next taken once the result is presented; the pace is set
// by the bit-serial multiplier (up to four uses per step) and the bit-serial divider.
// Reset (synchronous, active low): integrator and previous error to zero, gains zero.
module pid_controller_antiwindup #(
    parameter int DATA_WIDTH = pidaw_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = pidaw_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic signed [pidaw_pkg::ERROR_W-1:0] i_error,
    input  logic [pidaw_pkg::TIME_W-1:0]        i_time_step,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [DATA_WIDTH-1:0]        o_drive
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    // working width for saturating sums and for sign-extended 32-bit values
    localparam int SW = (DW + 2 > CFG_DATA_W + 1) ? DW + 2 : CFG_DATA_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_P_GO     = 4'd1;
    localparam logic [3:0] S_P_WAIT   = 4'd2;
    localparam logic [3:0] S_T_GO     = 4'd3;
    localparam logic [3:0] S_T_WAIT   = 4'd4;
    localparam logic [3:0] S_ICLAMP   = 4'd5;
    localparam logic [3:0] S_I_GO     = 4'd6;
    localparam logic [3:0] S_I_WAIT   = 4'd7;
    localparam logic [3:0] S_DIFF     = 4'd8;
    localparam logic [3:0] S_DIV_GO   = 4'd9;
    localparam logic [3:0] S_DIV_WAIT = 4'd10;
    localparam logic [3:0] S_D_GO     = 4'd11;
    localparam logic [3:0] S_D_WAIT   = 4'd12;
    localparam logic [3:0] S_SUM      = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    // --- helpers -------------------------------------------------------
    function automatic logic signed [SW-1:0] f_ext(input logic signed [DW-1:0] x);
        f_ext = {{(SW-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic signed [SW-1:0] f_ext32(input logic [CFG_DATA_W-1:0] x);
        f_ext32 = {{(SW-CFG_DATA_W){x[CFG_DATA_W-1]}}, x};
    endfunction

    // saturate to the signed DATA_WIDTH range
    function automatic logic signed [DW-1:0] f_sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi, lo;
        hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        lo = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
        if (x > hi) begin
            f_sat = hi[DW-1:0];
        end else if (x < lo) begin
            f_sat = lo[DW-1:0];
        end else begin
            f_sat = x[DW-1:0];
        end
    endfunction

    // upper test first: with an inverted window, above hi gives hi, anything else lo
    function automatic logic signed [DW-1:0] f_clamp(input logic signed [DW-1:0] x,
                                                     input logic signed [DW-1:0] hi,
                                                     input logic signed [DW-1:0] lo);
        if (x > hi) begin
            f_clamp = hi;
        end else if (x < lo) begin
            f_clamp = lo;
        end else begin
            f_clamp = x;
        end
    endfunction

    // --- configuration registers, held saturated to DATA_WIDTH ----------
    logic signed [DW-1:0] r_kp, r_ki, r_kd, r_iu, r_il, r_ou, r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
            r_iu <= f_sat(f_ext32(32'h7FFF_FFFF));
            r_il <= f_sat(f_ext32(32'h8000_0000));
            r_ou <= f_sat(f_ext32(32'h7FFF_FFFF));
            r_ol <= f_sat(f_ext32(32'h8000_0000));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP_GAIN:   r_kp <= f_sat(f_ext32(i_cfg_data));
                REG_INTEG_GAIN:  r_ki <= f_sat(f_ext32(i_cfg_data));
                REG_DERIV_GAIN:  r_kd <= f_sat(f_ext32(i_cfg_data));
                REG_INTEG_UPPER: r_iu <= f_sat(f_ext32(i_cfg_data));
                REG_INTEG_LOWER: r_il <= f_sat(f_ext32(i_cfg_data));
                REG_OUT_UPPER:   r_ou <= f_sat(f_ext32(i_cfg_data));
                REG_OUT_LOWER:   r_ol <= f_sat(f_ext32(i_cfg_data));
                default: ;  // index past the register file: write dropped
            endcase
        end
    end

    // --- datapath registers --------------------------------------------
    logic [3:0]           r_state;
    logic                 r_clr;
    logic signed [DW-1:0] r_err, r_last, r_integ;
    logic [TIME_W-1:0]    r_dt;
    logic signed [DW-1:0] r_p, r_i, r_d, r_q, r_diff, r_sum;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_drive;

    // --- shared serial multiplier --------------------------------------
    t_mul_req             mul_req;
    logic signed [DW:0]   mul_a, mul_b;
    logic                 mul_done;
    logic signed [DW-1:0] mul_prod;

    always_comb begin
        mul_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_P_GO: begin
                mul_req.start = 1'b1;
                mul_a = {r_kp[DW-1], r_kp};
                mul_b = {r_err[DW-1], r_err};
            end
            S_T_GO: begin
                // error * dt, dt is unsigned Q0.16
                mul_req.start      = 1'b1;
                mul_req.time_shift = 1'b1;
                mul_a = {r_err[DW-1], r_err};
                mul_b = {{(DW+1-TIME_W){1'b0}}, r_dt};
            end
            S_I_GO: begin
                mul_req.start = 1'b1;
                mul_a = {r_ki[DW-1], r_ki};
                mul_b = {r_integ[DW-1], r_integ};
            end
            S_D_GO: begin
                mul_req.start = 1'b1;
                mul_a = {r_kd[DW-1], r_kd};
                mul_b = {r_q[DW-1], r_q};
            end
            default: ;
        endcase
    end

    pidaw_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // --- serial divider for the derivative: |diff| << 16 / dt ----------
    logic               div_start, div_done;
    logic [DW:0]        diff_abs;
    logic signed [DW-1:0] div_quot;

    assign div_start = (r_state == S_DIV_GO);
    assign diff_abs  = r_diff[DW-1] ? -{r_diff[DW-1], r_diff} : {r_diff[DW-1], r_diff};

    pidaw_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (diff_abs[DW-1:0]),
        .i_neg     (r_diff[DW-1]),
        .i_divisor (r_dt),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // --- sequencer -----------------------------------------------------
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last      <= '0;
        end else begin
            // result presented from FINISH, dropped once transferred
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_operation == OP_CLEAR) begin
                            r_integ <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_P_GO;
                        end
                    end
                end
                S_P_GO:   r_state <= S_P_WAIT;
                S_P_WAIT: if (mul_done) r_state <= S_T_GO;
                S_T_GO:   r_state <= S_T_WAIT;
                S_T_WAIT: begin
                    if (mul_done) begin
                        r_integ <= f_sat(f_ext(r_integ) + f_ext(mul_prod));
                        r_state <= S_ICLAMP;
                    end
                end
                S_ICLAMP: begin
                    r_integ <= f_clamp(r_integ, r_iu, r_il);
                    r_state <= S_I_GO;
                end
                S_I_GO:   r_state <= S_I_WAIT;
                S_I_WAIT: begin
                    if (mul_done) begin
                        r_state <= (r_dt == '0) ? S_SUM : S_DIFF;
                    end
                end
                S_DIFF:     r_state <= S_DIV_GO;
                S_DIV_GO:   r_state <= S_DIV_WAIT;
                S_DIV_WAIT: if (div_done) r_state <= S_D_GO;
                S_D_GO:     r_state <= S_D_WAIT;
                S_D_WAIT:   if (mul_done) r_state <= S_SUM;
                S_SUM:      r_state <= S_FINISH;
                S_FINISH: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_last  <= r_clr ? '0 : r_err;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_clr <= (i_operation == OP_CLEAR);
                r_err <= f_sat(f_ext32(i_error));
                r_dt  <= i_time_step;
            end
            S_P_WAIT:   if (mul_done) r_p <= mul_prod;
            S_I_WAIT: begin
                if (mul_done) begin
                    r_i <= mul_prod;
                    r_d <= '0;  // zero time step: no derivative term
                end
            end
            S_DIFF:     r_diff <= f_sat(f_ext(r_err) - f_ext(r_last));
            S_DIV_WAIT: if (div_done) r_q <= div_quot;
            S_D_WAIT:   if (mul_done) r_d <= mul_prod;
            S_SUM:      r_sum <= f_sat(f_ext(r_p) + f_ext(r_i) + f_ext(r_d));
            S_FINISH: begin
                if (out_free) begin
                    r_drive <= r_clr ? '0 : f_clamp(r_sum, r_ou, r_ol);
                end
            end
            default: ;
        endcase
    end

    // no transfer is taken while reset is held
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pidaw_pkg::*;

    localparam int DW = DEF_DATA_WIDTH;
    localparam int FB = DEF_FRAC_BITS;

    // first index past the register file; writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_REGS = 7;

    localparam longint W_MAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint W_MIN = -(longint'(1) << (DW - 1));

    // worst-case step with a nonzero time step
    localparam int STEP_CYCLES = 4 * (DW + 3) + (DW + 16 + 3) + 4;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 2 * STEP_CYCLES;
    localparam int QUIET_LIMIT = 15 * STEP_CYCLES;

    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 100;

    // directed table: rows before PRED_FROM run on reset settings, so every drive is zero
    localparam int DIR_ROWS    = 24;
    localparam int PRED_FROM   = 6;
    localparam int INVERT_FROM = 20;

    typedef struct packed {
        logic        op;
        logic [31:0] err;
        logic [15:0] dt;
        logic        typed;   // drive below is the expectation, else the predictor's
        logic [31:0] drive;
    } t_stim_row;

    t_stim_row dir_rows [DIR_ROWS] = '{
        // reset settings: all gains zero
        '{OP_STEP,  32'h7FFF_FFFF, 16'hFFFF, 1'b1, 32'h0},
        '{OP_STEP,  32'h8000_0000, 16'h0001, 1'b1, 32'h0},
        '{OP_STEP,  32'h0000_0000, 16'h0000, 1'b1, 32'h0},
        '{OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0},
        '{OP_STEP,  32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0},
        '{OP_CLEAR, 32'h0000_0000, 16'h0000, 1'b1, 32'h0},
        // moderate gains, integrator window +-4.0, drive limits +-100.0
        '{OP_STEP,  32'h0001_0000, 16'h8000, 1'b0, 32'h0},
        '{OP_STEP,  32'hFFFF_0000, 16'h0000, 1'b0, 32'h0},   // zero time step
        '{OP_STEP,  32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h0},   // integrator hits upper
        '{OP_STEP,  32'h8000_0000, 16'h0001, 1'b0, 32'h0},   // difference saturates
        '{OP_STEP,  32'h8000_0000, 16'hFFFF, 1'b0, 32'h0},   // integrator hits lower
        '{OP_CLEAR, 32'h5555_5555, 16'hAAAA, 1'b1, 32'h0},
        '{OP_STEP,  32'h5555_5555, 16'h5555, 1'b0, 32'h0},
        '{OP_STEP,  32'hAAAA_AAAA, 16'hAAAA, 1'b0, 32'h0},
        '{OP_STEP,  32'h0000_0000, 16'hFFFF, 1'b0, 32'h0},
        '{OP_STEP,  32'hFFFF_FFFF, 16'h0001, 1'b0, 32'h0},
        '{OP_STEP,  32'h0000_0001, 16'h0001, 1'b0, 32'h0},
        '{OP_STEP,  32'h0064_0000, 16'h1000, 1'b0, 32'h0},   // drive hits upper
        '{OP_CLEAR, 32'hAAAA_AAAA, 16'h5555, 1'b1, 32'h0},
        '{OP_STEP,  32'hFF9C_0000, 16'h1000, 1'b0, 32'h0},   // drive hits lower
        // inverted window and limits: upper test wins
        '{OP_STEP,  32'h0002_0000, 16'h8000, 1'b0, 32'h0},
        '{OP_STEP,  32'hFFFE_0000, 16'h4000, 1'b0, 32'h0},
        '{OP_STEP,  32'h0000_0000, 16'h0000, 1'b0, 32'h0},
        '{OP_STEP,  32'h0000_8000, 16'h0100, 1'b0, 32'h0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_operation = OP_STEP;
    logic signed [ERROR_W-1:0]     i_error = '0;
    logic [TIME_W-1:0]             i_time_step = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [DW-1:0]          o_drive;

    pid_controller_antiwindup #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_error     (i_error),
        .i_time_step (i_time_step),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller mirror: registers, integrator and previous error
    // ------------------------------------------------------------------
    longint coef [NUM_REGS];
    longint integ_acc;
    longint prev_err;

    logic [DW-1:0] drive_q [$];

    bit in_steady  = 1'b0;     // sender runs without gaps
    bit out_steady = 1'b0;     // receiver takes every result at once

    int unsigned n_items, n_clears, n_zero_dt, n_results, n_cfg_sets, n_errors;
    int          quiet_cycles;
    logic [DW-1:0] mon_want;

    function automatic longint sat_dw(input longint x);
        if (x > W_MAX)
            return W_MAX;
        if (x < W_MIN)
            return W_MIN;
        return x;
    endfunction

    // a * b >> shift, magnitude truncated (rounds toward zero), then saturated
    function automatic longint scaled_product(input longint a, input longint b,
                                              input int shift);
        logic [63:0] ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma * mb) >> shift;
        return ((a < 0) != (b < 0)) ? sat_dw(-longint'(m)) : sat_dw(longint'(m));
    endfunction

    // upper test first, so with an inverted window a value above hi yields hi, any other lo
    function automatic longint bound(input longint x, input longint hi, input longint lo);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic logic [DW-1:0] next_drive(input logic op, input logic [31:0] err_in,
                                                 input logic [15:0] dt);
        longint err, p, ig, dv, diff, sum;
        logic [63:0] dmag, quo;
        err = longint'($signed(err_in));
        if (op == OP_CLEAR) begin
            integ_acc = 0;
            prev_err  = 0;
            return '0;
        end
        p = scaled_product(coef[REG_PROP_GAIN], err, FB);
        integ_acc = sat_dw(integ_acc + scaled_product(err, longint'({48'd0, dt}), TIME_FRAC));
        integ_acc = bound(integ_acc, coef[REG_INTEG_UPPER], coef[REG_INTEG_LOWER]);
        ig = scaled_product(coef[REG_INTEG_GAIN], integ_acc, FB);
        dv = 0;
        if (dt != 0) begin
            diff = sat_dw(err - prev_err);
            dmag = (diff < 0) ? -diff : diff;
            quo  = (dmag << TIME_FRAC) / dt;
            dv   = scaled_product(coef[REG_DERIV_GAIN],
                                  (diff < 0) ? sat_dw(-longint'(quo)) : sat_dw(longint'(quo)),
                                  FB);
        end
        sum = bound(sat_dw(p + ig + dv), coef[REG_OUT_UPPER], coef[REG_OUT_LOWER]);
        prev_err = err;
        return sum[DW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [DW-1:0] want,
                                   input logic [DW-1:0] got);
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        n_errors++;
    endtask

    // one register write, then the enable is taken low again before returning
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_REGS)
            coef[idx] = longint'($signed(val));
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] pg, input logic [31:0] ig,
                             input logic [31:0] dg, input logic [31:0] iu,
                             input logic [31:0] il, input logic [31:0] ou,
                             input logic [31:0] ol);
        write_reg(REG_PROP_GAIN,   pg);
        write_reg(REG_INTEG_GAIN,  ig);
        write_reg(REG_DERIV_GAIN,  dg);
        write_reg(REG_INTEG_UPPER, iu);
        write_reg(REG_INTEG_LOWER, il);
        write_reg(REG_OUT_UPPER,   ou);
        write_reg(REG_OUT_LOWER,   ol);
        write_reg(REG_UNUSED,      $urandom);   // must not disturb anything
        n_cfg_sets++;
    endtask

    // stop sending and wait for every outstanding drive to come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one input transfer; valid stays high when the next item follows without a gap
    task automatic send_item(input logic op, input logic [31:0] err, input logic [15:0] dt,
                             input logic typed, input logic [31:0] typed_drive);
        int gap;
        logic [DW-1:0] predicted;
        gap = in_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_error     <= err;
        i_time_step <= dt;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        predicted = next_drive(op, err, dt);
        drive_q.push_back(typed ? typed_drive : predicted);
        n_items++;
        if (op == OP_CLEAR)
            n_clears++;
        else if (dt == 0)
            n_zero_dt++;
    endtask

    function automatic logic [31:0] pick_error();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4, 5: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;  // +-2.0
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3, 4:    return 16'($urandom_range(1, 16'h0800));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h0;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;  // +-8.0
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0190_0000) - 32'h00C8_0000;  // +-200.0
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, then randomised phases
    // ------------------------------------------------------------------
    initial begin : stimulus
        int k, ph;
        t_stim_row row;
        logic [31:0] iu, il, ou, ol, tmp;
        coef[REG_PROP_GAIN]   = 0;
        coef[REG_INTEG_GAIN]  = 0;
        coef[REG_DERIV_GAIN]  = 0;
        coef[REG_INTEG_UPPER] = W_MAX;
        coef[REG_INTEG_LOWER] = W_MIN;
        coef[REG_OUT_UPPER]   = W_MAX;
        coef[REG_OUT_LOWER]   = W_MIN;
        integ_acc = 0;
        prev_err  = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (k == PRED_FROM) begin
                // P 1.0, I 0.5, D 0.25; integrator +-4.0; drive +-100.0
                settle();
                write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                          32'h0004_0000, 32'hFFFC_0000, 32'h0064_0000, 32'hFF9C_0000);
            end
            if (k == INVERT_FROM) begin
                // window -1.0 .. +1.0 and limits -2.0 .. +2.0, given upside down
                settle();
                write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                          32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0002_0000);
            end
            row = dir_rows[k];
            send_item(row.op, row.err, row.dt, row.typed, row.drive);
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                // every gain at its positive end, full window
                0: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
                // negative ends, window and limits fully inverted
                1: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
                // window and limits collapsed to zero
                2: write_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                             32'h0, 32'h0, 32'h0, 32'h0);
                default: begin
                    iu = pick_level();
                    il = pick_level();
                    ou = pick_level();
                    ol = pick_level();
                    // mostly ordered, sometimes left inverted
                    if ($urandom_range(0, 4) != 0 && $signed(iu) < $signed(il)) begin
                        tmp = iu;
                        iu  = il;
                        il  = tmp;
                    end
                    if ($urandom_range(0, 4) != 0 && $signed(ou) < $signed(ol)) begin
                        tmp = ou;
                        ou  = ol;
                        ol  = tmp;
                    end
                    write_all(pick_gain(), pick_gain(), pick_gain(), iu, il, ou, ol);
                end
            endcase
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_CLEAR, $urandom, 16'($urandom), 1'b0, '0);
                else
                    send_item(OP_STEP, pick_error(), pick_dt(), 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL) @(posedge i_clk);

        $display("covered %0d items (%0d clears, %0d steps with zero time step), %0d settings",
                 n_items, n_clears, n_zero_dt, n_cfg_sets);
        $display("%0d drive results compared, %0d mismatches", n_results, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: draws a stall length per result, raised ahead of the result and held after it shows
    // ------------------------------------------------------------------
    initial begin : out_side
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = out_steady ? 0 : $urandom_range(0, 13);
            i_out_stall <= (hold != 0);
            do @(posedge i_clk); while (!o_out_valid);
            if (hold != 0) begin
                repeat (hold - 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
                do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            end
        end
    end

    // result checker: each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (drive_q.size() == 0) begin
                report_mismatch("drive with nothing outstanding", 'x, o_drive);
            end else begin
                mon_want = drive_q.pop_front();
                if (o_drive !== mon_want)
                    report_mismatch("drive", mon_want, o_drive);
            end
        end
    end

    // watchdog: cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, %0d drives outstanding",
                     quiet_cycles, drive_q.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule
